@@ hdl/rbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg - shared types and constants for the ray/box slab test
// Request and result formats, configuration register indexes and the
// saturation limit used for slab distances.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int EPS_W     = 17;
	localparam int T_W       = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [T_W-1:0] T_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_X = 3'd0,
		CFG_MAX_X = 3'd1,
		CFG_MIN_Y = 3'd2,
		CFG_MAX_Y = 3'd3,
		CFG_MIN_Z = 3'd4,
		CFG_MAX_Z = 3'd5,
		CFG_EPS   = 3'd6
	} cfg_idx_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic ray_hits;
		logic origin_inside;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	// One axis worth of divide work: entry and exit numerators, shared divisor
	typedef struct packed {
		logic [COORD_W:0]   ent_mag;
		logic               ent_neg;
		logic [COORD_W:0]   ext_mag;
		logic               ext_neg;
		logic [COORD_W-1:0] den_mag;
		logic               den_neg;
	} slab_req_t;

	// Pick slab planes by direction sign, take magnitudes of the differences
	function automatic slab_req_t slab_prep(
		input logic [COORD_W-1:0] lo,
		input logic [COORD_W-1:0] hi,
		input logic [COORD_W-1:0] o,
		input logic [COORD_W-1:0] d
	);
		logic [COORD_W-1:0] b_ent;
		logic [COORD_W-1:0] b_ext;
		logic [COORD_W:0]   ent;
		logic [COORD_W:0]   ext;
		slab_req_t          r;
		b_ent = d[COORD_W-1] ? hi : lo;
		b_ext = d[COORD_W-1] ? lo : hi;
		ent = {b_ent[COORD_W-1], b_ent} - {o[COORD_W-1], o};
		ext = {b_ext[COORD_W-1], b_ext} - {o[COORD_W-1], o};
		r.ent_neg = ent[COORD_W];
		r.ent_mag = ent[COORD_W] ? (~ent + 1'b1) : ent;
		r.ext_neg = ext[COORD_W];
		r.ext_mag = ext[COORD_W] ? (~ext + 1'b1) : ext;
		r.den_neg = d[COORD_W-1];
		r.den_mag = d[COORD_W-1] ? (~d + 1'b1) : d;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_front - request entry stage
// Forms the slab numerators and divisor per axis and the strict
// origin-inside test, all registered in one stage.
// ----------------------------------------------------------------------------
module rbs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire rbs_pkg::ray_t     ray,
	input  wire rbs_pkg::box_t     box,
	output rbs_pkg::slab_req_t     req_x_s1,
	output rbs_pkg::slab_req_t     req_y_s1,
	output rbs_pkg::slab_req_t     req_z_s1,
	output logic                   inside_s1,
	output logic                   valid_s1
);

	logic org_in_box;

	// Strict containment on all three axes
	assign org_in_box = (ray.origin_x > box.min_x) && (ray.origin_x < box.max_x) &&
		(ray.origin_y > box.min_y) && (ray.origin_y < box.max_y) &&
		(ray.origin_z > box.min_z) && (ray.origin_z < box.max_z);

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Register per-axis divide requests
	always_ff @(posedge clk) begin
		req_x_s1  <= rbs_pkg::slab_prep(box.min_x, box.max_x, ray.origin_x, ray.dir_x);
		req_y_s1  <= rbs_pkg::slab_prep(box.min_y, box.max_y, ray.origin_y, ray.dir_y);
		req_z_s1  <= rbs_pkg::slab_prep(box.min_z, box.max_z, ray.origin_z, ray.dir_z);
		inside_s1 <= org_in_box;
	end

endmodule
`default_nettype wire

@@ hdl/rbs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_div - pipelined slab distance divider
// Restoring division, one quotient bit per stage, for the entry and exit
// numerators of one axis over a shared divisor; signed, saturated output.
// ----------------------------------------------------------------------------
module rbs_div #(
	parameter int FRAC_BITS = rbs_pkg::FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire rbs_pkg::slab_req_t                req,
	output logic                                   out_valid,
	output logic signed [rbs_pkg::T_W-1:0]         t_ent,
	output logic signed [rbs_pkg::T_W-1:0]         t_ext
);

	localparam int DW = rbs_pkg::COORD_W;
	localparam int NW = rbs_pkg::COORD_W + 1;
	localparam int QW = NW + FRAC_BITS;
	localparam int TW = rbs_pkg::T_W;
	localparam int XW = (QW > TW) ? QW : TW;

	// Stage arrays: index 0 is the incoming request, index k after k steps
	logic          valid_sk   [QW+1];
	logic [QW-1:0] n_ent_sk   [QW+1];
	logic [QW-1:0] n_ext_sk   [QW+1];
	logic [DW-1:0] r_ent_sk   [QW+1];
	logic [DW-1:0] r_ext_sk   [QW+1];
	logic [QW-1:0] q_ent_sk   [QW+1];
	logic [QW-1:0] q_ext_sk   [QW+1];
	logic [DW-1:0] den_sk     [QW+1];
	logic          den_neg_sk [QW+1];
	logic          ent_neg_sk [QW+1];
	logic          ext_neg_sk [QW+1];

	assign valid_sk[0]   = in_valid;
	assign n_ent_sk[0]   = {req.ent_mag, {FRAC_BITS{1'b0}}};
	assign n_ext_sk[0]   = {req.ext_mag, {FRAC_BITS{1'b0}}};
	assign r_ent_sk[0]   = '0;
	assign r_ext_sk[0]   = '0;
	assign q_ent_sk[0]   = '0;
	assign q_ext_sk[0]   = '0;
	assign den_sk[0]     = req.den_mag;
	assign den_neg_sk[0] = req.den_neg;
	assign ent_neg_sk[0] = req.ent_neg;
	assign ext_neg_sk[0] = req.ext_neg;

	// Form saturated signed distance from a finished quotient
	function automatic logic signed [TW-1:0] finish(
		input logic [QW-1:0] q,
		input logic          num_neg,
		input logic          num_zero,
		input logic          den_zero,
		input logic          den_neg
	);
		logic [XW-1:0] qx;
		logic [TW-1:0] mag;
		qx = XW'(q);
		if (qx > XW'(rbs_pkg::T_LIMIT)) begin
			mag = rbs_pkg::T_LIMIT;
		end else begin
			mag = qx[TW-1:0];
		end
		if (num_zero) begin
			finish = '0;
		end else if (den_zero) begin
			finish = num_neg ? -rbs_pkg::T_LIMIT : rbs_pkg::T_LIMIT;
		end else begin
			finish = (num_neg ^ den_neg) ? -$signed(mag) : $signed(mag);
		end
	endfunction

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_step
			logic [DW:0] trial_ent;
			logic [DW:0] trial_ext;
			logic        ge_ent;
			logic        ge_ext;

			// Bring down the next dividend bit and try the divisor
			always_comb begin
				trial_ent = {r_ent_sk[k], n_ent_sk[k][QW-1]};
				trial_ext = {r_ext_sk[k], n_ext_sk[k][QW-1]};
				ge_ent    = trial_ent >= {1'b0, den_sk[k]};
				ge_ext    = trial_ext >= {1'b0, den_sk[k]};
			end

			// Advance valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sk[k+1] <= 1'b0;
				end else begin
					valid_sk[k+1] <= valid_sk[k];
				end
			end

			// Advance partial remainders and quotients
			always_ff @(posedge clk) begin
				r_ent_sk[k+1]   <= ge_ent ? DW'(trial_ent - {1'b0, den_sk[k]})
					: trial_ent[DW-1:0];
				r_ext_sk[k+1]   <= ge_ext ? DW'(trial_ext - {1'b0, den_sk[k]})
					: trial_ext[DW-1:0];
				q_ent_sk[k+1]   <= {q_ent_sk[k][QW-2:0], ge_ent};
				q_ext_sk[k+1]   <= {q_ext_sk[k][QW-2:0], ge_ext};
				n_ent_sk[k+1]   <= {n_ent_sk[k][QW-2:0], 1'b0};
				n_ext_sk[k+1]   <= {n_ext_sk[k][QW-2:0], 1'b0};
				den_sk[k+1]     <= den_sk[k];
				den_neg_sk[k+1] <= den_neg_sk[k];
				ent_neg_sk[k+1] <= ent_neg_sk[k];
				ext_neg_sk[k+1] <= ext_neg_sk[k];
			end
		end
	endgenerate

	logic ent_zero_sk [QW+1];
	logic ext_zero_sk [QW+1];
	assign ent_zero_sk[0] = (req.ent_mag == '0);
	assign ext_zero_sk[0] = (req.ext_mag == '0);

	generate
		for (k = 0; k < QW; k++) begin : g_flag
			// Carry zero-numerator flags alongside
			always_ff @(posedge clk) begin
				ent_zero_sk[k+1] <= ent_zero_sk[k];
				ext_zero_sk[k+1] <= ext_zero_sk[k];
			end
		end
	endgenerate

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_sk[QW];
		end
	end

	// Sign, saturate and hold the distances
	always_ff @(posedge clk) begin
		t_ent <= finish(q_ent_sk[QW], ent_neg_sk[QW], ent_zero_sk[QW],
			den_sk[QW] == '0, den_neg_sk[QW]);
		t_ext <= finish(q_ext_sk[QW], ext_neg_sk[QW], ext_zero_sk[QW],
			den_sk[QW] == '0, den_neg_sk[QW]);
	end

endmodule
`default_nettype wire

@@ hdl/rbs_reduce.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_reduce - slab interval reduction
// Largest entry and smallest exit over three axes in two stages, then the
// hit compare against the exit threshold into the result register.
// ----------------------------------------------------------------------------
module rbs_reduce (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic signed [rbs_pkg::T_W-1:0]    tx_ent,
	input  wire logic signed [rbs_pkg::T_W-1:0]    tx_ext,
	input  wire logic signed [rbs_pkg::T_W-1:0]    ty_ent,
	input  wire logic signed [rbs_pkg::T_W-1:0]    ty_ext,
	input  wire logic signed [rbs_pkg::T_W-1:0]    tz_ent,
	input  wire logic signed [rbs_pkg::T_W-1:0]    tz_ext,
	input  wire logic                              in_box,
	input  wire logic [rbs_pkg::EPS_W-1:0]         eps,
	output logic                                   done,
	output rbs_pkg::result_t                       result
);

	localparam int TW = rbs_pkg::T_W;

	logic                 valid_s1, valid_s2;
	logic signed [TW-1:0] t0_s1, t1_s1, tz_ent_s1, tz_ext_s1;
	logic signed [TW-1:0] t0_s2, t1_s2;
	logic                 inside_s1, inside_s2;
	logic signed [TW-1:0] eps_t;

	assign eps_t = $signed(TW'(eps));

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	// Reduce x and y, hold z
	always_ff @(posedge clk) begin
		t0_s1     <= (tx_ent > ty_ent) ? tx_ent : ty_ent;
		t1_s1     <= (tx_ext < ty_ext) ? tx_ext : ty_ext;
		tz_ent_s1 <= tz_ent;
		tz_ext_s1 <= tz_ext;
		inside_s1 <= in_box;
	end

	// Fold in z
	always_ff @(posedge clk) begin
		t0_s2     <= (tz_ent_s1 > t0_s1) ? tz_ent_s1 : t0_s1;
		t1_s2     <= (tz_ext_s1 < t1_s1) ? tz_ext_s1 : t1_s1;
		inside_s2 <= inside_s1;
	end

	// Hit test into the result register
	always_ff @(posedge clk) begin
		result.ray_hits      <= (t0_s2 < t1_s2) && (t1_s2 > eps_t);
		result.origin_inside <= inside_s2;
	end

endmodule
`default_nettype wire

@@ hdl/ray_box_slab_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test - ray versus axis-aligned box slab test
// From start to done a request passes the front register, the bit-per-stage
// divider pipeline (COORD_W + 1 + FRAC_BITS steps) and the reduction registers.
// Throughput: one ray per cycle; busy stays low and done is a one-cycle
// strobe that the receiver cannot stall.
// Reset clears all valid bits and restores the box to +/-1.0 and the exit
// threshold to 7; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
	parameter int FRAC_BITS = rbs_pkg::FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire rbs_pkg::ray_t                     ray,
	output logic                                   done,
	output rbs_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rbs_pkg::COORD_W-1:0]       cfg_wdata
);

	localparam int CW      = rbs_pkg::COORD_W;
	localparam int QW      = CW + 1 + FRAC_BITS;
	localparam int DIV_LAT = QW + 1;
	localparam int LAT     = DIV_LAT + 4;
	localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

	rbs_pkg::box_t                box_q;
	logic [rbs_pkg::EPS_W-1:0]    eps_q;
	logic                         accept;
	logic                         valid_s1;
	rbs_pkg::slab_req_t           req_x_s1, req_y_s1, req_z_s1;
	logic                         inside_s1;
	logic                         vx, vy, vz;
	logic signed [rbs_pkg::T_W-1:0] tx_ent, tx_ext, ty_ent, ty_ext, tz_ent, tz_ext;
	logic                         inside_dl [DIV_LAT+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.min_x <= -ONE;
			box_q.max_x <= ONE;
			box_q.min_y <= -ONE;
			box_q.max_y <= ONE;
			box_q.min_z <= -ONE;
			box_q.max_z <= ONE;
			eps_q       <= rbs_pkg::EPS_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbs_pkg::CFG_MIN_X: box_q.min_x <= cfg_wdata;
				rbs_pkg::CFG_MAX_X: box_q.max_x <= cfg_wdata;
				rbs_pkg::CFG_MIN_Y: box_q.min_y <= cfg_wdata;
				rbs_pkg::CFG_MAX_Y: box_q.max_y <= cfg_wdata;
				rbs_pkg::CFG_MIN_Z: box_q.min_z <= cfg_wdata;
				rbs_pkg::CFG_MAX_Z: box_q.max_z <= cfg_wdata;
				rbs_pkg::CFG_EPS:   eps_q       <= cfg_wdata[rbs_pkg::EPS_W-1:0];
				default: ;
			endcase
		end
	end

	rbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.ray       (ray),
		.box       (box_q),
		.req_x_s1  (req_x_s1),
		.req_y_s1  (req_y_s1),
		.req_z_s1  (req_z_s1),
		.inside_s1 (inside_s1),
		.valid_s1  (valid_s1)
	);

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .req (req_x_s1),
		.out_valid (vx), .t_ent (tx_ent), .t_ext (tx_ext)
	);

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .req (req_y_s1),
		.out_valid (vy), .t_ent (ty_ent), .t_ext (ty_ext)
	);

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .req (req_z_s1),
		.out_valid (vz), .t_ent (tz_ent), .t_ext (tz_ext)
	);

	// Delay the inside flag alongside the dividers
	assign inside_dl[0] = inside_s1;
	genvar k;
	generate
		for (k = 0; k < DIV_LAT; k++) begin : g_dl
			always_ff @(posedge clk) begin
				inside_dl[k+1] <= inside_dl[k];
			end
		end
	endgenerate

	rbs_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vx && vy && vz),
		.tx_ent   (tx_ent),
		.tx_ext   (tx_ext),
		.ty_ent   (ty_ent),
		.ty_ext   (ty_ext),
		.tz_ent   (tz_ent),
		.tz_ext   (tz_ext),
		.in_box   (inside_dl[DIV_LAT]),
		.eps      (eps_q),
		.done     (done),
		.result   (result)
	);

	// Axis dividers stay in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vx == vy) && (vy == vz))
		else $error("axis divider valid bits diverged");

	// Every result comes from a request accepted a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching request");

	// Reduction carries the divider output through valid_s1 and valid_s2 into done
	a_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vx, 3))
		else $error("result not fed by divider output");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the ray/box slab test
// Drives rays through the start/busy request port, rewrites the box and the
// exit threshold between phases, and checks every done strobe against the
// hit/inside pair typed for some rows or computed alongside in fixed point.
// ----------------------------------------------------------------------------
module tb;

	localparam int ONE = 65536;
	localparam logic [rbs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		rbs_pkg::ray_t    r;
		bit               typed;
		rbs_pkg::result_t want;
	} ray_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	rbs_pkg::ray_t                 ray;
	logic                          done;
	rbs_pkg::result_t              result;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rbs_pkg::COORD_W-1:0]   cfg_wdata;

	rbs_pkg::box_t             box_now;
	logic [rbs_pkg::EPS_W-1:0] eps_now;
	rbs_pkg::result_t          pending_results[$];
	int                        mismatches;
	int                        cycles;
	int                        row_ptr;
	ray_row_t                  rows[$];

	ray_box_slab_test DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ray(ray),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Signed distance (bound - origin) / dir with FRAC_BITS fraction bits, saturating
	function automatic longint slab_dist(longint num, longint den);
		longint unsigned n;
		longint unsigned d;
		longint unsigned q;
		bit neg;
		if (num == 0) return 0;
		if (den == 0) begin
			return (num > 0) ? longint'(rbs_pkg::T_LIMIT) : -longint'(rbs_pkg::T_LIMIT);
		end
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = (n << rbs_pkg::FRAC_BITS) / d;
		if (q > longint'(rbs_pkg::T_LIMIT)) q = rbs_pkg::T_LIMIT;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic rbs_pkg::result_t predict_hit(rbs_pkg::ray_t r);
		longint lo[3];
		longint hi[3];
		longint o[3];
		longint d[3];
		longint tin;
		longint tout;
		longint t0;
		longint t1;
		rbs_pkg::result_t p;
		lo = '{box_now.min_x, box_now.min_y, box_now.min_z};
		hi = '{box_now.max_x, box_now.max_y, box_now.max_z};
		o = '{r.origin_x, r.origin_y, r.origin_z};
		d = '{r.dir_x, r.dir_y, r.dir_z};
		t0 = -longint'(rbs_pkg::T_LIMIT) - 1;
		t1 = longint'(rbs_pkg::T_LIMIT) + 1;
		p.origin_inside = 1'b1;
		for (int a = 0; a < 3; a++) begin
			// swap entry and exit planes for a negative direction
			if (d[a] >= 0) begin
				tin = slab_dist(lo[a] - o[a], d[a]);
				tout = slab_dist(hi[a] - o[a], d[a]);
			end else begin
				tin = slab_dist(hi[a] - o[a], d[a]);
				tout = slab_dist(lo[a] - o[a], d[a]);
			end
			if (tin > t0) t0 = tin;
			if (tout < t1) t1 = tout;
			if (!(o[a] > lo[a] && o[a] < hi[a])) p.origin_inside = 1'b0;
		end
		p.ray_hits = (t0 < t1) && (t1 > longint'({47'd0, eps_now}));
		return p;
	endfunction

	// Track accepted requests, config writes and check results
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rbs_pkg::CFG_MIN_X: box_now.min_x = cfg_wdata;
					rbs_pkg::CFG_MAX_X: box_now.max_x = cfg_wdata;
					rbs_pkg::CFG_MIN_Y: box_now.min_y = cfg_wdata;
					rbs_pkg::CFG_MAX_Y: box_now.max_y = cfg_wdata;
					rbs_pkg::CFG_MIN_Z: box_now.min_z = cfg_wdata;
					rbs_pkg::CFG_MAX_Z: box_now.max_z = cfg_wdata;
					rbs_pkg::CFG_EPS:   eps_now = cfg_wdata[rbs_pkg::EPS_W-1:0];
					default: ;
				endcase
			end
			// Directed rows come first, in order; typed rows carry their own answer
			if (start && !busy) begin
				if (row_ptr < rows.size()) begin
					pending_results.push_back(rows[row_ptr].typed ? rows[row_ptr].want
						: predict_hit(ray));
					row_ptr++;
				end else begin
					pending_results.push_back(predict_hit(ray));
				end
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: hits=%0b inside=%0b",
						result.ray_hits, result.origin_inside);
					mismatches++;
				end else begin
					rbs_pkg::result_t w;
					w = pending_results.pop_front();
					if (w.ray_hits !== result.ray_hits) begin
						$error("ray_hits expected %0b actual %0b", w.ray_hits, result.ray_hits);
						mismatches++;
					end
					if (w.origin_inside !== result.origin_inside) begin
						$error("origin_inside expected %0b actual %0b",
							w.origin_inside, result.origin_inside);
						mismatches++;
					end
				end
			end
		end
	end

	function automatic rbs_pkg::ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		rbs_pkg::ray_t r;
		r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
		r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
		return r;
	endfunction

	// Hold one request until the block takes it, then maybe idle a while
	task automatic send_ray(rbs_pkg::ray_t r, bit idle_ok);
		start <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Present one write and wait for it to be taken; valid stays high on return
	task automatic write_reg(logic [rbs_pkg::CFG_IDX_W-1:0] idx,
		logic [rbs_pkg::COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Let the pipeline empty before touching registers
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_box(int mnx, int mxx, int mny, int mxy, int mnz, int mxz,
		logic [rbs_pkg::COORD_W-1:0] eps);
		write_reg(rbs_pkg::CFG_MIN_X, mnx);
		write_reg(rbs_pkg::CFG_MAX_X, mxx);
		write_reg(rbs_pkg::CFG_MIN_Y, mny);
		write_reg(rbs_pkg::CFG_MAX_Y, mxy);
		write_reg(rbs_pkg::CFG_MIN_Z, mnz);
		write_reg(rbs_pkg::CFG_MAX_Z, mxz);
		write_reg(rbs_pkg::CFG_EPS, eps);
	endtask

	function automatic int rand_coord(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Random ray: mostly aimed at a point near the box, some raw noise
	function automatic rbs_pkg::ray_t rand_ray();
		rbs_pkg::ray_t r;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			r.origin_x = rand_coord(4 * ONE);
			r.origin_y = rand_coord(4 * ONE);
			r.origin_z = rand_coord(4 * ONE);
			r.dir_x = rand_coord(ONE) - r.origin_x;
			r.dir_y = rand_coord(ONE) - r.origin_y;
			r.dir_z = rand_coord(ONE) - r.origin_z;
			if (sel == 9) begin
				case ($urandom_range(0, 2))
					0: r.dir_x = 0;
					1: r.dir_y = 0;
					default: r.dir_z = 0;
				endcase
			end
			if (sel == 8) r.dir_x = -r.dir_x;
		end
		return r;
	endfunction

	initial begin
		ray_row_t row;
		int lo;
		arst_n = 1'b0;
		start = 1'b0;
		ray = '0;
		cfg_valid = 1'b0;
		cfg_index = rbs_pkg::CFG_MIN_X;
		cfg_wdata = '0;
		mismatches = 0;
		cycles = 0;
		row_ptr = 0;
		box_now = '{-ONE, ONE, -ONE, ONE, -ONE, ONE};
		eps_now = 7;

		// Directed rows against the reset box
		row.typed = 1;
		row.r = mk_ray(-2 * ONE, 0, 0, ONE, 0, 0); row.want = 2'b10; rows.push_back(row);
		row.r = mk_ray(0, 0, 0, 0, 0, 0); row.want = 2'b11; rows.push_back(row);
		row.r = mk_ray(2 * ONE, 0, 0, ONE, 0, 0); row.want = 2'b00; rows.push_back(row);
		row.r = mk_ray(ONE, 0, 0, 0, 0, 0); row.want = 2'b00; rows.push_back(row);
		row.r = mk_ray(-2 * ONE, 0, 0, -ONE, 0, 0); row.want = 2'b00; rows.push_back(row);
		row.r = mk_ray(-2 * ONE, ONE, 0, ONE, 0, 0); row.want = 2'b00; rows.push_back(row);
		row.typed = 0;
		row.r = {6{32'h7FFF_FFFF}}; rows.push_back(row);
		row.r = {6{32'h8000_0000}}; rows.push_back(row);
		row.r = {{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}; rows.push_back(row);
		row.r = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}}; rows.push_back(row);
		row.r = mk_ray(0, 0, 0, -1, -1, -1); rows.push_back(row);
		row.r = mk_ray(-5 * ONE, -5 * ONE, -5 * ONE, 1, 1, 1); rows.push_back(row);
		row.r = {6{32'hFFFF_FFFF}}; rows.push_back(row);
		row.r = {6{32'h5555_5555}}; rows.push_back(row);
		row.r = {6{32'hAAAA_AAAA}}; rows.push_back(row);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table back to back
		for (int i = 0; i < rows.size(); i++) begin
			start <= 1'b1;
			ray <= rows[i].r;
			@(posedge clk);
			while (busy) @(posedge clk);
		end

		// Phases of box settings, random rays in each
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: load_box(-ONE, ONE, -ONE, ONE, -ONE, ONE, 0);
				1: load_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 65536);
				2: load_box(ONE, -ONE, ONE, -ONE, ONE, -ONE, 7);
				3: begin
					load_box(-ONE / 2, 2 * ONE, -3 * ONE, ONE / 4, -ONE, 3 * ONE, $urandom);
					write_reg(CFG_UNUSED, $urandom);
				end
				default: begin
					lo = rand_coord(2 * ONE);
					load_box(lo, lo + $urandom_range(0, 2 * ONE), -rand_coord(ONE),
						$urandom_range(0, 2 * ONE), -$urandom_range(0, ONE),
						$urandom_range(0, ONE), $urandom_range(0, 300));
				end
			endcase
			cfg_valid <= 1'b0;
			for (int i = 0; i < 190; i++)
				send_ray(rand_ray(), !(ph == 5 && i >= 60));
		end

		// Wait for the pipeline to empty, then settle
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
